// File: rtl/core/nmat_pkg.sv
`timescale 1ns / 1ps

package nmat_pkg;

    // chunk geometry
    localparam int CHUNK_SIDE = 16;
    localparam int CW         = 4;
    localparam int DEPTH      = CHUNK_SIDE * CHUNK_SIDE;
    localparam int AW         = $clog2(DEPTH);

    // random word and remainder loop
    localparam int RND_W = 15;

    // opcodes
    localparam logic [2:0] OP_PLACE   = 3'd0;
    localparam logic [2:0] OP_QUIET   = 3'd1;
    localparam logic [2:0] OP_REMOVE  = 3'd2;
    localparam logic [2:0] OP_REFRESH = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    // cell directions, in update order
    localparam logic [2:0] DIR_UP    = 3'd0;
    localparam logic [2:0] DIR_LEFT  = 3'd1;
    localparam logic [2:0] DIR_CTR   = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_DOWN  = 3'd4;
    localparam logic [2:0] DIR_END   = 3'd5;

    // register indexes on the apb port
    localparam logic [1:0] REG_VAR_COUNT = 2'd0;
    localparam logic [1:0] REG_OFFSET_U  = 2'd1;
    localparam logic [1:0] REG_OFFSET_V  = 2'd2;

    // tile byte fields
    localparam int PRESENT_BIT = 7;

    // texture offsets per neighbour mask
    localparam logic [5:0] TEX_U [16] = '{
        6'd48, 6'd48, 6'd0, 6'd0, 6'd32, 6'd32, 6'd16, 6'd16,
        6'd48, 6'd48, 6'd0, 6'd0, 6'd32, 6'd32, 6'd16, 6'd16
    };
    localparam logic [5:0] TEX_V [16] = '{
        6'd48, 6'd0, 6'd48, 6'd0, 6'd48, 6'd0, 6'd48, 6'd0,
        6'd32, 6'd16, 6'd32, 6'd16, 6'd32, 6'd16, 6'd32, 6'd16
    };

    typedef struct packed {
        logic          ok;
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
    } t_cell;

    // neighbour of (x,y) in a direction, with an inside-chunk flag
    function automatic t_cell cell_of(logic [CW-1:0] x, logic [CW-1:0] y, logic [2:0] dir);
        t_cell c;
        c.ok = 1'b1;
        c.cx = x;
        c.cy = y;
        case (dir)
            DIR_UP: begin
                c.ok = (y != '0);
                c.cy = y - CW'(1);
            end
            DIR_LEFT: begin
                c.ok = (x != '0);
                c.cx = x - CW'(1);
            end
            DIR_CTR: begin
                c.ok = 1'b1;
            end
            DIR_RIGHT: begin
                c.ok = (int'(x) < CHUNK_SIDE - 1);
                c.cx = x + CW'(1);
            end
            DIR_DOWN: begin
                c.ok = (int'(y) < CHUNK_SIDE - 1);
                c.cy = y + CW'(1);
            end
            default: begin
                c.ok = 1'b0;
            end
        endcase
        return c;
    endfunction

    // store address of a cell, row major
    function automatic logic [AW-1:0] addr_of(logic [CW-1:0] x, logic [CW-1:0] y);
        return AW'(int'(y) * CHUNK_SIDE + int'(x));
    endfunction

endpackage

// File: rtl/core/nmat_ram.sv
`timescale 1ns / 1ps

module nmat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// File: rtl/core/neighbour_mask_autotiler.sv
// Autotiler for one 16 x 16 chunk of tile bytes held in a single-port-read block RAM. Each
// byte carries a present bit, a 3-bit variation and an up/left/right/down neighbour mask.
// An item is taken only while o_in_ready is high, i.e. while the sequencer is idle; a
// result beat may still be waiting on the output then. Every store read goes through the
// one RAM read port, one address a cycle: each updated cell takes an address step, reads of
// the cell and its four neighbours and a write back. Place runs a centre check, a bit-serial
// remainder of the 15-bit random word, a centre write and the five cells; quiet place skips
// the check, remove writes the centre and updates the five cells, and refresh and read
// handle the one cell. Results of an item are held back by one beat so that the final one
// can carry o_last, and a slow output consumer stalls the sequencer. Reset is synchronous
// and clears the store at once through per-entry valid flops, so no clearing pass is needed.
`timescale 1ns / 1ps

module neighbour_mask_autotiler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_cell_x,
    input  logic [3:0]  i_cell_y,
    input  logic [14:0] i_random_word,
    input  logic [2:0]  i_left_edge_bits,
    input  logic [2:0]  i_right_edge_bits,
    input  logic [2:0]  i_up_edge_bits,
    input  logic [2:0]  i_down_edge_bits,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_out_x,
    output logic [3:0]  o_out_y,
    output logic [7:0]  o_tile_byte,
    output logic [12:0] o_tex_u,
    output logic [12:0] o_tex_v,
    output logic        o_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHK   = 9'b000000010,
        S_CHKW  = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_WRC   = 9'b000010000,
        S_CELL  = 9'b000100000,
        S_FETCH = 9'b001000000,
        S_WB    = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    localparam int CW = nmat_pkg::CW;
    localparam int AW = nmat_pkg::AW;

    t_state r_state, n_state;

    // latched item
    logic [2:0]              r_op;
    logic [CW-1:0]           r_x, r_y;
    logic [nmat_pkg::RND_W-1:0] r_rnd;
    logic [2:0]              r_le, r_re, r_ue, r_de;

    // sequencer working registers
    logic [2:0]    r_k;
    logic [2:0]    r_j;
    logic [CW-1:0] r_cx, r_cy;
    logic [7:0]    r_ctr;
    logic [3:0]    r_mask;
    logic [3:0]    r_rem;
    logic [3:0]    r_dcnt;

    // configuration
    logic [3:0]  r_vcnt;
    logic [11:0] r_off_u, r_off_v;

    // store valid flags and read side
    logic [nmat_pkg::DEPTH-1:0] r_valid;
    logic                       r_rd_vld;
    logic [7:0]                 w_ram_q;
    logic [7:0]                 w_rdata;

    // held-back result and output register
    logic        r_pend_v;
    logic [3:0]  r_pend_x, r_pend_y;
    logic [7:0]  r_pend_byte;
    logic [12:0] r_pend_u, r_pend_v_tex;
    logic        r_out_valid;
    logic [3:0]  r_out_x, r_out_y;
    logic [7:0]  r_out_byte;
    logic [12:0] r_out_u, r_out_v;
    logic        r_out_last;

    logic            w_acc_in, w_out_free, w_in_range;
    nmat_pkg::t_cell w_cell, w_nb, w_nbp;
    logic [2:0]      w_prev;
    logic [1:0]      w_ex, w_ey;
    logic            w_edge, w_nb_bit;
    logic [AW-1:0]   w_ctr_addr, w_raddr, w_waddr;
    logic            w_we;
    logic [7:0]      w_wdata;
    logic [3:0]      w_cnt_eff;
    logic [4:0]      w_trial;
    logic [3:0]      w_rem_nx;
    logic            w_report, w_single, w_last_cell, w_emit_now, w_wb_stall;
    logic            w_out_load;
    logic [7:0]      w_res_byte;
    logic [12:0]     w_res_u, w_res_v;
    logic            w_cfg_wr;

    assign w_acc_in   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_in_range = (int'(i_cell_x) < nmat_pkg::CHUNK_SIDE)
                     && (int'(i_cell_y) < nmat_pkg::CHUNK_SIDE);

    // cell under update and the neighbour being read / captured
    assign w_cell     = nmat_pkg::cell_of(r_x, r_y, r_k);
    assign w_nb       = nmat_pkg::cell_of(r_cx, r_cy, r_j);
    assign w_prev     = r_j - 3'd1;
    assign w_nbp      = nmat_pkg::cell_of(r_cx, r_cy, w_prev);
    assign w_ctr_addr = nmat_pkg::addr_of(r_x, r_y);

    // edge bit position from the cell offset to the addressed cell
    assign w_ex = (r_k == nmat_pkg::DIR_LEFT)  ? 2'd0 :
                  (r_k == nmat_pkg::DIR_RIGHT) ? 2'd2 : 2'd1;
    assign w_ey = (r_k == nmat_pkg::DIR_UP)    ? 2'd0 :
                  (r_k == nmat_pkg::DIR_DOWN)  ? 2'd2 : 2'd1;

    always_comb begin
        case (w_prev)
            nmat_pkg::DIR_UP:    w_edge = r_ue[w_ex];
            nmat_pkg::DIR_LEFT:  w_edge = r_le[w_ey];
            nmat_pkg::DIR_RIGHT: w_edge = r_re[w_ey];
            nmat_pkg::DIR_DOWN:  w_edge = r_de[w_ex];
            default:             w_edge = 1'b0;
        endcase
    end

    assign w_rdata  = r_rd_vld ? w_ram_q : 8'd0;
    assign w_nb_bit = w_nbp.ok ? w_rdata[nmat_pkg::PRESENT_BIT] : w_edge;

    // bit-serial remainder step
    assign w_cnt_eff = (r_vcnt == 4'd0) ? 4'd1 : r_vcnt;
    assign w_trial   = {r_rem, r_rnd[nmat_pkg::RND_W-1]};
    assign w_rem_nx  = (w_trial >= {1'b0, w_cnt_eff}) ? 4'(w_trial - {1'b0, w_cnt_eff})
                                                      : w_trial[3:0];

    // op classes
    assign w_report    = (r_op != nmat_pkg::OP_QUIET);
    assign w_single    = r_op inside {nmat_pkg::OP_REFRESH, nmat_pkg::OP_READ};
    assign w_last_cell = w_single || (r_k == nmat_pkg::DIR_DOWN);
    assign w_emit_now  = (r_op == nmat_pkg::OP_READ)
                      || (r_ctr[nmat_pkg::PRESENT_BIT] && w_report);
    assign w_wb_stall  = w_emit_now && r_pend_v && !w_out_free;

    // a held-back beat moves into the output register
    assign w_out_load  = ((r_state == S_WB) && w_emit_now && !w_wb_stall && r_pend_v)
                      || ((r_state == S_FIN) && r_pend_v && w_out_free);

    // result of the current cell
    assign w_res_byte = (r_op == nmat_pkg::OP_READ) ? r_ctr : {r_ctr[7:4], r_mask};
    assign w_res_u    = (r_op == nmat_pkg::OP_READ) ? 13'd0
                      : 13'(r_off_u) + 13'(nmat_pkg::TEX_U[r_mask])
                        + {4'd0, r_ctr[6:4], 6'd0};
    assign w_res_v    = (r_op == nmat_pkg::OP_READ) ? 13'd0
                      : 13'(r_off_v) + 13'(nmat_pkg::TEX_V[r_mask]);

    // store ports
    assign w_raddr = (r_state == S_FETCH) ? nmat_pkg::addr_of(w_nb.cx, w_nb.cy) : w_ctr_addr;
    assign w_we    = (r_state == S_WRC)
                  || ((r_state == S_WB) && (r_op != nmat_pkg::OP_READ)
                      && r_ctr[nmat_pkg::PRESENT_BIT]);
    assign w_waddr = (r_state == S_WRC) ? w_ctr_addr : nmat_pkg::addr_of(r_cx, r_cy);
    assign w_wdata = (r_state == S_WRC)
                   ? ((r_op == nmat_pkg::OP_REMOVE) ? 8'd0 : {1'b1, r_rem[2:0], 4'd0})
                   : {r_ctr[7:4], r_mask};

    nmat_ram #(
        .WIDTH (8),
        .DEPTH (nmat_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc_in && w_in_range) begin
                    case (i_opcode)
                        nmat_pkg::OP_PLACE:   n_state = S_CHK;
                        nmat_pkg::OP_QUIET:   n_state = S_DIV;
                        nmat_pkg::OP_REMOVE:  n_state = S_WRC;
                        nmat_pkg::OP_REFRESH: n_state = S_CELL;
                        nmat_pkg::OP_READ:    n_state = S_CELL;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_CHK:  n_state = S_CHKW;
            S_CHKW: n_state = w_rdata[nmat_pkg::PRESENT_BIT] ? S_IDLE : S_DIV;
            S_DIV: begin
                if (r_dcnt == 4'(nmat_pkg::RND_W - 1)) begin
                    n_state = S_WRC;
                end
            end
            S_WRC: n_state = S_CELL;
            S_CELL: begin
                if (w_cell.ok) begin
                    n_state = S_FETCH;
                end else if (w_last_cell) begin
                    n_state = S_FIN;
                end
            end
            S_FETCH: begin
                if (r_j == nmat_pkg::DIR_END) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (!w_wb_stall) begin
                    n_state = w_last_cell ? S_FIN : S_CELL;
                end
            end
            S_FIN: begin
                if (!r_pend_v || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_vcnt      <= 4'd1;
            r_off_u     <= 12'd0;
            r_off_v     <= 12'd0;
        end else begin
            r_state <= n_state;
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            // output beat loaded or taken
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // new result held back
            if ((r_state == S_WB) && w_emit_now && !w_wb_stall) begin
                r_pend_v <= 1'b1;
            end
            // final result of the item
            if ((r_state == S_FIN) && r_pend_v && w_out_free) begin
                r_pend_v <= 1'b0;
            end
            // register writes
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    nmat_pkg::REG_VAR_COUNT: r_vcnt  <= pwdata[3:0];
                    nmat_pkg::REG_OFFSET_U:  r_off_u <= pwdata[11:0];
                    nmat_pkg::REG_OFFSET_V:  r_off_v <= pwdata[11:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[w_raddr];

        if (w_acc_in) begin
            r_op   <= i_opcode;
            r_x    <= i_cell_x;
            r_y    <= i_cell_y;
            r_rnd  <= i_random_word;
            r_le   <= i_left_edge_bits;
            r_re   <= i_right_edge_bits;
            r_ue   <= i_up_edge_bits;
            r_de   <= i_down_edge_bits;
            r_rem  <= 4'd0;
            r_dcnt <= 4'd0;
            r_k    <= nmat_pkg::DIR_CTR;
        end

        case (r_state)
            S_DIV: begin
                r_rem  <= w_rem_nx;
                r_rnd  <= {r_rnd[nmat_pkg::RND_W-2:0], 1'b0};
                r_dcnt <= r_dcnt + 4'd1;
            end
            S_WRC: begin
                r_k <= nmat_pkg::DIR_UP;
            end
            S_CELL: begin
                r_cx <= w_cell.cx;
                r_cy <= w_cell.cy;
                r_j  <= nmat_pkg::DIR_UP;
                if (!w_cell.ok) begin
                    r_k <= r_k + 3'd1;
                end
            end
            S_FETCH: begin
                r_j <= r_j + 3'd1;
                if (r_j != nmat_pkg::DIR_UP) begin
                    case (w_prev)
                        nmat_pkg::DIR_UP:    r_mask[3] <= w_nb_bit;
                        nmat_pkg::DIR_LEFT:  r_mask[2] <= w_nb_bit;
                        nmat_pkg::DIR_CTR:   r_ctr     <= w_rdata;
                        nmat_pkg::DIR_RIGHT: r_mask[1] <= w_nb_bit;
                        nmat_pkg::DIR_DOWN:  r_mask[0] <= w_nb_bit;
                        default: ;
                    endcase
                end
            end
            S_WB: begin
                if (!w_wb_stall) begin
                    r_k <= r_k + 3'd1;
                    if (w_emit_now) begin
                        r_pend_x     <= r_cx;
                        r_pend_y     <= r_cy;
                        r_pend_byte  <= w_res_byte;
                        r_pend_u     <= w_res_u;
                        r_pend_v_tex <= w_res_v;
                        if (r_pend_v) begin
                            r_out_x    <= r_pend_x;
                            r_out_y    <= r_pend_y;
                            r_out_byte <= r_pend_byte;
                            r_out_u    <= r_pend_u;
                            r_out_v    <= r_pend_v_tex;
                            r_out_last <= 1'b0;
                        end
                    end
                end
            end
            S_FIN: begin
                if (r_pend_v && w_out_free) begin
                    r_out_x    <= r_pend_x;
                    r_out_y    <= r_pend_y;
                    r_out_byte <= r_pend_byte;
                    r_out_u    <= r_pend_u;
                    r_out_v    <= r_pend_v_tex;
                    r_out_last <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // apb side
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        case (paddr[3:2])
            nmat_pkg::REG_VAR_COUNT: prdata = {28'd0, r_vcnt};
            nmat_pkg::REG_OFFSET_U:  prdata = {20'd0, r_off_u};
            nmat_pkg::REG_OFFSET_V:  prdata = {20'd0, r_off_v};
            default:                 prdata = 32'd0;
        endcase
    end

    // ports
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_tile_byte = r_out_byte;
    assign o_tex_u     = r_out_u;
    assign o_tex_v     = r_out_v;
    assign o_last      = r_out_last;

    // no held-back result survives into the next item
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_pend_v)
        else $error("result still held back while taking a new item");

    // quiet place never produces results
    a_quiet_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_op != nmat_pkg::OP_QUIET))
        else $error("result held back for a quiet place");

    // remainder loop ends below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRC) && (r_op != nmat_pkg::OP_REMOVE)) |-> (r_rem < w_cnt_eff))
        else $error("variation remainder not reduced");

endmodule

// File: tb/tb_neighbour_mask_autotiler.sv
`timescale 1ns / 1ps

module tb_neighbour_mask_autotiler;

    // names shared with the design
    localparam int         CHUNK_SIDE    = nmat_pkg::CHUNK_SIDE;
    localparam logic [2:0] OP_PLACE      = nmat_pkg::OP_PLACE;
    localparam logic [2:0] OP_QUIET      = nmat_pkg::OP_QUIET;
    localparam logic [2:0] OP_REMOVE     = nmat_pkg::OP_REMOVE;
    localparam logic [2:0] OP_REFRESH    = nmat_pkg::OP_REFRESH;
    localparam logic [2:0] OP_READ       = nmat_pkg::OP_READ;
    localparam logic [1:0] REG_VAR_COUNT = nmat_pkg::REG_VAR_COUNT;
    localparam logic [1:0] REG_OFFSET_U  = nmat_pkg::REG_OFFSET_U;
    localparam logic [1:0] REG_OFFSET_V  = nmat_pkg::REG_OFFSET_V;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 120;
    localparam int PREDICT       = -1;
    localparam int RANDOM_EDITS  = 28;

    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

    // texture offsets per neighbour mask
    localparam int TEX_U_OF_MASK [16] = '{
        48, 48, 0, 0, 32, 32, 16, 16, 48, 48, 0, 0, 32, 32, 16, 16
    };
    localparam int TEX_V_OF_MASK [16] = '{
        48, 0, 48, 0, 48, 0, 48, 0, 32, 16, 32, 16, 32, 16, 32, 16
    };

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  cell_x;
        logic [3:0]  cell_y;
        logic [14:0] rnd;
        logic [2:0]  left_bits;
        logic [2:0]  right_bits;
        logic [2:0]  up_bits;
        logic [2:0]  down_bits;
    } t_tile_edit;

    typedef struct packed {
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  tile;
        logic [12:0] tex_u;
        logic [12:0] tex_v;
        logic        last;
    } t_tile_beat;

    // n_typed: PREDICT, or the number of hand-written result beats (0 or 1)
    typedef struct packed {
        t_tile_edit  edit;
        int          n_typed;
        logic [7:0]  typed_byte;
    } t_edit_row;

    localparam int N_DIRECTED = 25;
    localparam t_edit_row DIRECTED [N_DIRECTED] = '{
        // reads of an empty chunk at both corners
        '{'{OP_READ,    4'd0,  4'd0,  15'h0000, 3'd0, 3'd0, 3'd0, 3'd0}, 1, 8'h00},
        '{'{OP_READ,    4'd15, 4'd15, 15'h7fff, 3'd7, 3'd7, 3'd7, 3'd7}, 1, 8'h00},
        // refresh of an absent cell, unused opcodes
        '{'{OP_REFRESH, 4'd5,  4'd5,  15'h0000, 3'd7, 3'd7, 3'd7, 3'd7}, 0, 8'h00},
        '{'{OP_FIRST_UNUSED, 4'd3, 4'd3, 15'h7fff, 3'd7, 3'd7, 3'd7, 3'd7}, 0, 8'h00},
        '{'{OP_LAST_UNUSED,  4'd3, 4'd3, 15'h7fff, 3'd7, 3'd7, 3'd7, 3'd7}, 0, 8'h00},
        // corner place with full edges, then place on a present cell
        '{'{OP_PLACE,   4'd0,  4'd0,  15'h7fff, 3'd7, 3'd7, 3'd7, 3'd7}, PREDICT, 8'h00},
        '{'{OP_PLACE,   4'd0,  4'd0,  15'h0000, 3'd0, 3'd0, 3'd0, 3'd0}, 0, 8'h00},
        '{'{OP_READ,    4'd0,  4'd0,  15'h0000, 3'd0, 3'd0, 3'd0, 3'd0}, PREDICT, 8'h00},
        '{'{OP_PLACE,   4'd1,  4'd0,  15'h1234, 3'd0, 3'd0, 3'd7, 3'd0}, PREDICT, 8'h00},
        '{'{OP_PLACE,   4'd0,  4'd1,  15'h0000, 3'd7, 3'd0, 3'd0, 3'd0}, PREDICT, 8'h00},
        '{'{OP_REFRESH, 4'd0,  4'd0,  15'h0000, 3'd0, 3'd0, 3'd0, 3'd0}, PREDICT, 8'h00},
        // quiet place over a present cell and on an empty one
        '{'{OP_QUIET,   4'd1,  4'd0,  15'h5555, 3'd7, 3'd7, 3'd7, 3'd7}, 0, 8'h00},
        '{'{OP_QUIET,   4'd1,  4'd1,  15'h2aaa, 3'd0, 3'd0, 3'd0, 3'd0}, 0, 8'h00},
        '{'{OP_REMOVE,  4'd0,  4'd0,  15'h0000, 3'd7, 3'd7, 3'd7, 3'd7}, PREDICT, 8'h00},
        // the other three corners
        '{'{OP_PLACE,   4'd15, 4'd15, 15'h7fff, 3'd7, 3'd7, 3'd7, 3'd7}, PREDICT, 8'h00},
        '{'{OP_PLACE,   4'd15, 4'd0,  15'h0000, 3'd0, 3'd7, 3'd7, 3'd0}, PREDICT, 8'h00},
        '{'{OP_PLACE,   4'd0,  4'd15, 15'h0000, 3'd7, 3'd0, 3'd0, 3'd7}, PREDICT, 8'h00},
        // a cross in mid chunk: the centre updates all five cells
        '{'{OP_PLACE,   4'd7,  4'd6,  15'h0001, 3'd0, 3'd0, 3'd0, 3'd0}, PREDICT, 8'h00},
        '{'{OP_PLACE,   4'd6,  4'd7,  15'h0002, 3'd0, 3'd0, 3'd0, 3'd0}, PREDICT, 8'h00},
        '{'{OP_PLACE,   4'd8,  4'd7,  15'h0003, 3'd0, 3'd0, 3'd0, 3'd0}, PREDICT, 8'h00},
        '{'{OP_PLACE,   4'd7,  4'd8,  15'h0004, 3'd0, 3'd0, 3'd0, 3'd0}, PREDICT, 8'h00},
        '{'{OP_PLACE,   4'd7,  4'd7,  15'h7fff, 3'd7, 3'd7, 3'd7, 3'd7}, PREDICT, 8'h00},
        '{'{OP_REMOVE,  4'd7,  4'd7,  15'h0000, 3'd7, 3'd7, 3'd7, 3'd7}, PREDICT, 8'h00},
        '{'{OP_READ,    4'd7,  4'd7,  15'h0000, 3'd0, 3'd0, 3'd0, 3'd0}, 1, 8'h00},
        '{'{OP_REMOVE,  4'd15, 4'd15, 15'h0000, 3'd7, 3'd7, 3'd7, 3'd7}, PREDICT, 8'h00}
    };

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_opcode = '0;
    logic [3:0]  i_cell_x = '0;
    logic [3:0]  i_cell_y = '0;
    logic [14:0] i_random_word = '0;
    logic [2:0]  i_left_edge_bits = '0;
    logic [2:0]  i_right_edge_bits = '0;
    logic [2:0]  i_up_edge_bits = '0;
    logic [2:0]  i_down_edge_bits = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  o_out_x;
    logic [3:0]  o_out_y;
    logic [7:0]  o_tile_byte;
    logic [12:0] o_tex_u;
    logic [12:0] o_tex_v;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    neighbour_mask_autotiler uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_cell_x          (i_cell_x),
        .i_cell_y          (i_cell_y),
        .i_random_word     (i_random_word),
        .i_left_edge_bits  (i_left_edge_bits),
        .i_right_edge_bits (i_right_edge_bits),
        .i_up_edge_bits    (i_up_edge_bits),
        .i_down_edge_bits  (i_down_edge_bits),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_out_x           (o_out_x),
        .o_out_y           (o_out_y),
        .o_tile_byte       (o_tile_byte),
        .o_tex_u           (o_tex_u),
        .o_tex_v           (o_tex_v),
        .o_last            (o_last),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // shadow chunk and registers
    logic [7:0]  chunk_tiles [CHUNK_SIDE * CHUNK_SIDE];
    logic [3:0]  var_count_cfg = 4'd1;
    logic [11:0] offset_u_cfg  = '0;
    logic [11:0] offset_v_cfg  = '0;

    t_tile_beat  pending_beats [$];
    t_tile_beat  fresh_beats [$];

    int failures      = 0;
    int beats_seen    = 0;
    int edits_sent    = 0;
    int cycles        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int op_count [8];

    always #1 i_clk = ~i_clk;

    // receiver stalls
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still due", cycles,
                     pending_beats.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    // compare each result beat with the oldest one due
    always @(posedge i_clk) begin : beat_check
        t_tile_beat want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected result beat at cell (%0d,%0d)", o_out_x, o_out_y);
                failures++;
            end else begin
                want = pending_beats.pop_front();
                check_field("out_x", want.x, o_out_x);
                check_field("out_y", want.y, o_out_y);
                check_field("tile_byte", want.tile, o_tile_byte);
                check_field("tex_u", want.tex_u, o_tex_u);
                check_field("tex_v", want.tex_v, o_tex_v);
                check_field("last", want.last, o_last);
                beats_seen++;
            end
        end
    end

    function automatic logic is_present(int cx, int cy);
        return chunk_tiles[cy * CHUNK_SIDE + cx][7];
    endfunction

    // presence beyond the chunk, d is the offset from the addressed cell
    function automatic logic edge_bit(logic [2:0] bits, int d);
        if (d < -1 || d > 1)
            return 1'b0;
        return bits[d + 1];
    endfunction

    task automatic recompute_mask(int cx, int cy, t_tile_edit e);
        logic [7:0] t;
        logic [3:0] m;
        int         ax;
        int         ay;
        ax = e.cell_x;
        ay = e.cell_y;
        t  = chunk_tiles[cy * CHUNK_SIDE + cx];
        if (!t[7])
            return;
        m[3] = (cy > 0) ? is_present(cx, cy - 1) : edge_bit(e.up_bits, cx - ax);
        m[2] = (cx > 0) ? is_present(cx - 1, cy) : edge_bit(e.left_bits, cy - ay);
        m[1] = (cx < CHUNK_SIDE - 1) ? is_present(cx + 1, cy)
                                     : edge_bit(e.right_bits, cy - ay);
        m[0] = (cy < CHUNK_SIDE - 1) ? is_present(cx, cy + 1)
                                     : edge_bit(e.down_bits, cx - ax);
        chunk_tiles[cy * CHUNK_SIDE + cx] = {t[7:4], m};
    endtask

    task automatic emit_texture(int cx, int cy);
        t_tile_beat b;
        logic [7:0] t;
        t = chunk_tiles[cy * CHUNK_SIDE + cx];
        if (!t[7])
            return;
        b.x     = 4'(cx);
        b.y     = 4'(cy);
        b.tile  = t;
        b.tex_u = 13'(int'(offset_u_cfg) + TEX_U_OF_MASK[t[3:0]] + 64 * int'(t[6:4]));
        b.tex_v = 13'(int'(offset_v_cfg) + TEX_V_OF_MASK[t[3:0]]);
        b.last  = 1'b0;
        fresh_beats.push_back(b);
    endtask

    // the cell and its up, left, right and down edge neighbours, in update order
    task automatic update_cross(t_tile_edit e, bit report);
        int dxs [5] = '{0, -1, 0, 1, 0};
        int dys [5] = '{-1, 0, 0, 0, 1};
        int cx;
        int cy;
        for (int k = 0; k < 5; k++) begin
            cx = int'(e.cell_x) + dxs[k];
            cy = int'(e.cell_y) + dys[k];
            if (cx < 0 || cx >= CHUNK_SIDE || cy < 0 || cy >= CHUNK_SIDE)
                continue;
            recompute_mask(cx, cy, e);
            if (report)
                emit_texture(cx, cy);
        end
    endtask

    function automatic logic [7:0] fresh_tile(logic [14:0] rnd);
        int unsigned divisor;
        int unsigned variation;
        divisor   = (var_count_cfg == 0) ? 1 : var_count_cfg;
        variation = (int'(rnd) % divisor) & 7;
        return {1'b1, 3'(variation), 4'b0000};
    endfunction

    // apply one edit to the shadow chunk, results land in fresh_beats
    task automatic predict_edit(t_tile_edit e);
        int         idx;
        t_tile_beat b;
        fresh_beats.delete();
        idx = int'(e.cell_y) * CHUNK_SIDE + int'(e.cell_x);
        case (e.opcode)
            OP_PLACE: begin
                if (!chunk_tiles[idx][7]) begin
                    chunk_tiles[idx] = fresh_tile(e.rnd);
                    update_cross(e, 1'b1);
                end
            end
            OP_QUIET: begin
                chunk_tiles[idx] = fresh_tile(e.rnd);
                update_cross(e, 1'b0);
            end
            OP_REMOVE: begin
                chunk_tiles[idx] = '0;
                update_cross(e, 1'b1);
            end
            OP_REFRESH: begin
                recompute_mask(e.cell_x, e.cell_y, e);
                emit_texture(e.cell_x, e.cell_y);
            end
            OP_READ: begin
                b = '{x: e.cell_x, y: e.cell_y, tile: chunk_tiles[idx],
                      tex_u: '0, tex_v: '0, last: 1'b0};
                fresh_beats.push_back(b);
            end
            default: begin
            end
        endcase
        if (fresh_beats.size() > 0)
            fresh_beats[fresh_beats.size() - 1].last = 1'b1;
    endtask

    // drive one edit beat and book its results once accepted
    task automatic send_edit(t_tile_edit e, int n_typed, logic [7:0] typed_byte);
        t_tile_beat b;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid          <= 1'b1;
        i_opcode          <= e.opcode;
        i_cell_x          <= e.cell_x;
        i_cell_y          <= e.cell_y;
        i_random_word     <= e.rnd;
        i_left_edge_bits  <= e.left_bits;
        i_right_edge_bits <= e.right_bits;
        i_up_edge_bits    <= e.up_bits;
        i_down_edge_bits  <= e.down_bits;
        do @(posedge i_clk); while (!o_in_ready);
        predict_edit(e);
        op_count[e.opcode]++;
        edits_sent++;
        if (n_typed == PREDICT) begin
            foreach (fresh_beats[i])
                pending_beats.push_back(fresh_beats[i]);
        end else if (n_typed == 1) begin
            b = '{x: e.cell_x, y: e.cell_y, tile: typed_byte,
                  tex_u: '0, tex_v: '0, last: 1'b1};
            pending_beats.push_back(b);
        end
    endtask

    // stop sending and let the block run dry
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(bit wr, logic [1:0] idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write all three registers and read them back
    task automatic set_config(logic [3:0] vc, logic [11:0] ou, logic [11:0] ov);
        logic [31:0] rd;
        apb_access(1'b1, REG_VAR_COUNT, 32'(vc), rd);
        apb_access(1'b1, REG_OFFSET_U, 32'(ou), rd);
        apb_access(1'b1, REG_OFFSET_V, 32'(ov), rd);
        var_count_cfg = vc;
        offset_u_cfg  = ou;
        offset_v_cfg  = ov;
        apb_access(1'b0, REG_VAR_COUNT, '0, rd);
        check_field("variation_count readback", vc, rd);
        apb_access(1'b0, REG_OFFSET_U, '0, rd);
        check_field("tileset_offset_u readback", ou, rd);
        apb_access(1'b0, REG_OFFSET_V, '0, rd);
        check_field("tileset_offset_v readback", ov, rd);
    endtask

    // coordinates cluster at the edges and the middle so neighbours meet
    function automatic logic [3:0] pick_coord();
        case ($urandom_range(3))
            0:       return 4'($urandom_range(2));
            1:       return 4'($urandom_range(15, 13));
            2:       return 4'($urandom_range(8, 6));
            default: return 4'($urandom_range(15));
        endcase
    endfunction

    function automatic t_tile_edit random_edit();
        t_tile_edit e;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 35)
            e.opcode = OP_PLACE;
        else if (pick < 45)
            e.opcode = OP_QUIET;
        else if (pick < 65)
            e.opcode = OP_REMOVE;
        else if (pick < 80)
            e.opcode = OP_REFRESH;
        else if (pick < 95)
            e.opcode = OP_READ;
        else
            e.opcode = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
        e.cell_x     = pick_coord();
        e.cell_y     = pick_coord();
        e.rnd        = 15'($urandom_range(32767));
        e.left_bits  = 3'($urandom_range(7));
        e.right_bits = 3'($urandom_range(7));
        e.up_bits    = 3'($urandom_range(7));
        e.down_bits  = 3'($urandom_range(7));
        return e;
    endfunction

    // random edits; ignored opcodes do not count
    task automatic run_random(int n_edits, bit pause_midway);
        t_tile_edit e;
        int         counted;
        bit         paused;
        counted = 0;
        paused  = 1'b0;
        while (counted < n_edits) begin
            e = random_edit();
            send_edit(e, PREDICT, '0);
            if (e.opcode <= OP_READ)
                counted++;
            if (pause_midway && !paused && counted >= n_edits / 2) begin
                paused = 1'b1;
                @(negedge i_clk);
                in_valid <= 1'b0;
                while (pending_beats.size() != 0)
                    @(posedge i_clk);
            end
        end
        drain();
    endtask

    initial begin
        foreach (chunk_tiles[i])
            chunk_tiles[i] = '0;
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed edits under reset settings
        send_idle_pct = 29;
        recv_idle_pct = 81;
        for (int r = 0; r < N_DIRECTED; r++)
            send_edit(DIRECTED[r].edit, DIRECTED[r].n_typed, DIRECTED[r].typed_byte);
        drain();

        // a count of eight variations, offsets at their 12-bit maximum within the 13-bit outputs
        set_config(4'd8, 12'hfff, 12'hfff);
        run_random(RANDOM_EDITS, 1'b1);

        // count of zero behaves as one
        send_idle_pct = 81;
        recv_idle_pct = 29;
        set_config(4'd0, 12'($urandom_range(4095)), 12'd0);
        run_random(RANDOM_EDITS, 1'b0);

        // widest count the field holds
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(4'd15, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
        run_random(RANDOM_EDITS, 1'b0);

        $display("covered %0d edits: %0d place, %0d quiet place, %0d remove, %0d refresh,",
                 edits_sent, op_count[OP_PLACE], op_count[OP_QUIET], op_count[OP_REMOVE],
                 op_count[OP_REFRESH]);
        $display("%0d read, %0d unused; %0d result beats over four register settings",
                 op_count[OP_READ],
                 op_count[OP_FIRST_UNUSED] + op_count[OP_FIRST_UNUSED + 3'd1]
                     + op_count[OP_LAST_UNUSED],
                 beats_seen);
        if (failures == 0 && pending_beats.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d beats never arrived", failures, pending_beats.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
